[src/hlcm_pkg.sv]
// ----------------------------------------------------------------------------
// hlcm_pkg
// Shared types and constants of the Hough line cluster merge block.
// ----------------------------------------------------------------------------
package hlcm_pkg;

    localparam int PI_Q      = 25736;
    localparam int HALF_PI_Q = 12868;

    localparam int DIVIDEND_W = 31;
    localparam int DIVISOR_W  = 17;
    localparam int QUOT_W     = 16;

    typedef enum logic [1:0] {
        CFG_ANGLE_TOL       = 2'd0,
        CFG_MERGE_THETA_TOL = 2'd1,
        CFG_MERGE_RHO_TOL   = 2'd2,
        CFG_NONE            = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic signed [15:0] rho;
        logic signed [15:0] theta;
        logic [15:0]        cnt;
    } t_entry;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_DIVS  = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_WRITE = 7'b0100000,
        ST_FLUSH = 7'b1000000
    } t_state;

endpackage

[src/hlcm_cell.sv]
// ----------------------------------------------------------------------------
// hlcm_cell
// One cluster slot of the rotating ring; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module hlcm_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  hlcm_pkg::t_entry i_d,
    output hlcm_pkg::t_entry o_q
);
    import hlcm_pkg::*;

    t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

[src/hlcm_div.sv]
// ----------------------------------------------------------------------------
// hlcm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hlcm_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [hlcm_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [hlcm_pkg::DIVISOR_W-1:0]      i_divisor,
    output logic                                o_busy,
    output logic [hlcm_pkg::QUOT_W-1:0]         o_quot
);
    import hlcm_pkg::*;

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W:0]    r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_div;
    logic [CW-1:0]         r_cnt;
    logic [DIVISOR_W:0]    w_rem_sh;
    logic                  w_ge;

    assign w_rem_sh = {r_rem[DIVISOR_W-1:0], r_quo[DIVIDEND_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(DIVIDEND_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quo[QUOT_W-1:0];

endmodule

[src/hough_line_cluster_merge.sv]
// ----------------------------------------------------------------------------
// hough_line_cluster_merge
// Merges Hough lines into clusters held in a rotating ring of cells.
// ----------------------------------------------------------------------------
// A kept line word holds the input while the cluster ring makes one full
// turn past the compare cell at its head. A line that joins a cluster also
// holds the ring for a multiply and the 31-step divider. A flush word holds
// the input while the ring makes one full turn, one cluster word per ring
// step, plus any output stall; a flush of an empty table holds it until its
// single empty word can be loaded. A dropped line without a flush frees the
// input at once. Words are taken one at a time.
module hough_line_cluster_merge #(
    parameter int MAX_CLUSTERS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_carries_line,
    input  logic signed [15:0] i_line_rho,
    input  logic [14:0]        i_line_theta,
    input  logic               i_last_line,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_merged_rho,
    output logic [14:0]        o_merged_theta,
    output logic [15:0]        o_merged_count,
    output logic               o_table_empty,
    output logic               o_overflow_seen,
    output logic               o_last_result
);
    import hlcm_pkg::*;

    localparam int SW = $clog2(MAX_CLUSTERS + 1);
    localparam logic [SW-1:0] MAX_C = SW'(MAX_CLUSTERS);
    localparam logic signed [17:0] PI_S   = 18'(PI_Q);
    localparam logic signed [17:0] HALF_S = 18'(HALF_PI_Q);

    t_state  r_state, n_state;
    logic [SW-1:0] r_step, n_step, r_used, n_used;
    logic    r_ovf, n_ovf, r_done, n_done;
    logic [12:0] r_angle_tol, r_theta_tol;
    logic [14:0] r_rho_tol;
    logic signed [15:0] r_rho, r_theta;
    logic    r_last;
    logic signed [32:0] r_prod_rho, r_prod_th;
    logic    r_neg_rho, r_neg_th;

    logic    r_o_valid;
    logic signed [15:0] r_o_rho;
    logic [14:0] r_o_theta;
    logic [15:0] r_o_cnt;
    logic    r_o_empty, r_o_ovf, r_o_last;

    t_entry  w_q [MAX_CLUSTERS];
    t_entry  w_head, w_feed, w_upd;
    logic    w_shift, w_load_out, w_out_free, w_in_acc, w_div_start;
    logic    w_o_empty, w_o_last;
    logic signed [15:0] w_o_rho;
    logic [14:0] w_o_theta;

    // line preprocessing
    logic signed [17:0] w_th_raw, w_tol, w_th;
    logic [15:0] w_rho_abs;
    logic    w_keep;

    assign w_tol    = {5'b0, r_angle_tol};
    assign w_th_raw = {3'b0, i_line_theta};
    assign w_th     = (w_th_raw >= PI_S - w_tol) ? (w_th_raw - PI_S) : w_th_raw;
    assign w_keep   = ((HALF_S - w_tol <= w_th) && (w_th <= HALF_S + w_tol))
                   || (w_th <= w_tol) || (PI_S - w_tol < w_th);
    assign w_rho_abs = !i_line_rho[15] ? i_line_rho :
                       (i_line_rho == 16'sh8000) ? 16'd32767 : 16'(-i_line_rho);

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = r_state == ST_IDLE;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_o_valid || i_out_ready;

    // cell ring
    genvar g;
    generate
        for (g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
            t_entry w_d;
            if (g == MAX_CLUSTERS - 1) begin : g_tail
                assign w_d = w_feed;
            end else begin : g_mid
                assign w_d = w_q[g+1];
            end
            hlcm_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_d     (w_d),
                .o_q     (w_q[g])
            );
        end
    endgenerate

    assign w_head = w_q[0];

    // match at head
    logic signed [16:0] w_drho, w_dth;
    logic [16:0] w_adrho, w_adth;
    logic    w_match;

    assign w_drho  = {w_head.rho[15], w_head.rho} - {r_rho[15], r_rho};
    assign w_dth   = {w_head.theta[15], w_head.theta} - {r_theta[15], r_theta};
    assign w_adrho = w_drho[16] ? 17'(-w_drho) : w_drho;
    assign w_adth  = w_dth[16] ? 17'(-w_dth) : w_dth;
    assign w_match = (w_adrho < {2'b0, r_rho_tol}) && (w_adth < {4'b0, r_theta_tol});

    // running average divide
    logic signed [33:0] w_sum_rho, w_sum_th;
    logic [DIVIDEND_W-1:0] w_mag_rho, w_mag_th;
    logic [DIVISOR_W-1:0]  w_divisor;
    logic [QUOT_W-1:0]     w_q_rho, w_q_th;
    logic    w_busy_rho, w_busy_th;

    assign w_sum_rho = {r_prod_rho[32], r_prod_rho} + {{18{r_rho[15]}}, r_rho};
    assign w_sum_th  = {r_prod_th[32], r_prod_th} + {{18{r_theta[15]}}, r_theta};
    assign w_mag_rho = w_sum_rho[33] ? DIVIDEND_W'(-w_sum_rho) : DIVIDEND_W'(w_sum_rho);
    assign w_mag_th  = w_sum_th[33] ? DIVIDEND_W'(-w_sum_th) : DIVIDEND_W'(w_sum_th);
    assign w_divisor = {1'b0, w_head.cnt} + 17'd1;
    assign w_div_start = r_state == ST_DIVS;

    hlcm_div u_div_rho (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag_rho),
        .i_divisor  (w_divisor),
        .o_busy     (w_busy_rho),
        .o_quot     (w_q_rho)
    );

    hlcm_div u_div_th (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag_th),
        .i_divisor  (w_divisor),
        .o_busy     (w_busy_th),
        .o_quot     (w_q_th)
    );

    assign w_upd.rho   = r_neg_rho ? 16'(-w_q_rho) : w_q_rho;
    assign w_upd.theta = r_neg_th ? 16'(-w_q_th) : w_q_th;
    assign w_upd.cnt   = (w_head.cnt == 16'hFFFF) ? w_head.cnt : w_head.cnt + 16'd1;

    // flush word
    assign w_o_rho   = w_head.theta[15] ? 16'(-w_head.rho) : w_head.rho;
    assign w_o_theta = w_head.theta[15] ? 15'(w_head.theta + 16'(PI_Q))
                                        : w_head.theta[14:0];

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_used     = r_used;
        n_ovf      = r_ovf;
        n_done     = r_done;
        w_shift    = 1'b0;
        w_feed     = w_head;
        w_load_out = 1'b0;
        w_o_empty  = 1'b0;
        w_o_last   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_step = '0;
                    n_done = 1'b0;
                    if (i_carries_line && w_keep) begin
                        n_state = ST_SCAN;
                    end else if (i_last_line) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_SCAN: begin
                if (r_step == MAX_C) begin
                    n_step = '0;
                    if (!r_done) begin
                        n_ovf = 1'b1;
                    end
                    n_state = r_last ? ST_FLUSH : ST_IDLE;
                end else if (!r_done && r_step < r_used && w_match) begin
                    n_state = ST_MUL;
                end else begin
                    w_shift = 1'b1;
                    n_step  = r_step + 1'b1;
                    if (!r_done && r_step == r_used) begin
                        w_feed.rho   = r_rho;
                        w_feed.theta = r_theta;
                        w_feed.cnt   = 16'd1;
                        n_used       = r_used + 1'b1;
                        n_done       = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                n_state = ST_DIVS;
            end
            ST_DIVS: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!w_busy_rho && !w_busy_th) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                w_shift = 1'b1;
                w_feed  = w_upd;
                n_step  = r_step + 1'b1;
                n_done  = 1'b1;
                n_state = ST_SCAN;
            end
            ST_FLUSH: begin
                if (r_used == '0) begin
                    if (w_out_free) begin
                        w_load_out = 1'b1;
                        w_o_empty  = 1'b1;
                        w_o_last   = 1'b1;
                        n_ovf      = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end else if (r_step == MAX_C) begin
                    n_step  = '0;
                    n_used  = '0;
                    n_ovf   = 1'b0;
                    n_state = ST_IDLE;
                end else if (r_step >= r_used || w_out_free) begin
                    w_shift    = 1'b1;
                    n_step     = r_step + 1'b1;
                    w_load_out = r_step < r_used;
                    w_o_last   = r_step + 1'b1 == r_used;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_used      <= '0;
            r_ovf       <= 1'b0;
            r_done      <= 1'b0;
            r_o_valid   <= 1'b0;
            r_angle_tol <= 13'd82;
            r_theta_tol <= 13'd82;
            r_rho_tol   <= 15'd400;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_used  <= n_used;
            r_ovf   <= n_ovf;
            r_done  <= n_done;
            if (w_load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_ANGLE_TOL:       r_angle_tol <= i_cfg_data[12:0];
                    CFG_MERGE_THETA_TOL: r_theta_tol <= i_cfg_data[12:0];
                    CFG_MERGE_RHO_TOL:   r_rho_tol   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rho   <= w_rho_abs;
            r_theta <= w_th[15:0];
            r_last  <= i_last_line;
        end
        if (r_state == ST_MUL) begin
            r_prod_rho <= w_head.rho * $signed({1'b0, w_head.cnt});
            r_prod_th  <= w_head.theta * $signed({1'b0, w_head.cnt});
        end
        if (w_div_start) begin
            r_neg_rho <= w_sum_rho[33];
            r_neg_th  <= w_sum_th[33];
        end
        if (w_load_out) begin
            r_o_rho   <= w_o_empty ? 16'sd0 : w_o_rho;
            r_o_theta <= w_o_empty ? 15'd0 : w_o_theta;
            r_o_cnt   <= w_o_empty ? 16'd0 : w_head.cnt;
            r_o_empty <= w_o_empty;
            r_o_ovf   <= r_ovf;
            r_o_last  <= w_o_last;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_merged_rho    = r_o_rho;
    assign o_merged_theta  = r_o_theta;
    assign o_merged_count  = r_o_cnt;
    assign o_table_empty   = r_o_empty;
    assign o_overflow_seen = r_o_ovf;
    assign o_last_result   = r_o_last;

endmodule
